### rtl/core/flim_intensity_mean_arrival_assert.svh
// assertion macros for the flim mean arrival time block
// expects clk and rst_n in the scope where a macro is used
`ifndef FLIM_INTENSITY_MEAN_ARRIVAL_ASSERT_SVH
`define FLIM_INTENSITY_MEAN_ARRIVAL_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FIMA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fima assertion failed");

// consequent must hold in the cycle after the antecedent
`define FIMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fima assertion failed");

`endif

### rtl/core/fima_pkg.sv
// shared types and constants of the flim mean arrival time block
// no dependencies
package fima_pkg;

    localparam int CNT_W      = 28;
    localparam int WSUM_W     = 44;
    localparam int MEAN_W     = 24;
    localparam int FRAC_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int TIME_W     = 16;
    localparam int PROD_W     = COUNT_W + TIME_W;
    localparam int ALU_W      = WSUM_W + 1;
    localparam int DIV_STEPS  = MEAN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    // quotient overflows when weighted_sum >= count_sum << OVF_SHIFT
    localparam int OVF_SHIFT  = MEAN_W - FRAC_W;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  bin_time;
        logic               last_bin;
    } bin_t;

    typedef struct packed {
        logic [CNT_W-1:0]  intensity;
        logic [MEAN_W-1:0] mean_arrival;
        logic              zero_intensity;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD_W,
        S_ADD_C,
        S_CHECK,
        S_DIV,
        S_HOLD
    } state_t;

endpackage

### rtl/core/flim_intensity_mean_arrival.sv
// flim mean arrival time: per-pixel intensity and count-weighted mean bin time
// depends on fima_pkg and flim_intensity_mean_arrival_assert.svh
//
// One histogram bin is taken per transaction. A bin that is not the last of its
// pixel passes through the 16x16 multiplier, then the weighted sum and the
// intensity sum each take a turn through the single 45-bit add/subtract unit,
// before the next bin can be accepted. A last bin adds one overflow compare and
// 24 restoring division steps on that same unit, and a load of the result
// register. An empty pixel or one whose mean saturates skips the division and
// goes from the compare straight to the load. If the
// previous result has not been taken yet, the block waits in the load cycle.
// The result register lets the next bin be accepted while a result is still
// pending. The mean is floor(weighted_sum * 256 / intensity) in Q16.8,
// saturating at all ones; an empty pixel gives mean 0 with zero_intensity set.
// Both sums saturate and are cleared after each pixel.
`include "flim_intensity_mean_arrival_assert.svh"

module flim_intensity_mean_arrival (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             bin_valid,
    output logic             bin_ready,
    input  fima_pkg::bin_t    bin,
    output logic             res_valid,
    input  logic             res_ready,
    output fima_pkg::result_t res
);
    import fima_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]    tm_reg;
    logic                 last_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [CNT_W-1:0]     csum_reg;
    logic [WSUM_W-1:0]    wsum_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [MEAN_W-1:0]    dshift_reg;
    logic [MEAN_W-1:0]    quo_reg;
    logic                 zero_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 res_valid_reg;
    result_t              res_reg;

    // shared add/subtract unit
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W-1:0] alu_res;
    logic             alu_ge;

    logic             bin_acc;
    logic             res_free;
    logic             csum_zero;
    logic [CNT_W:0]   div_r;

    assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_ge    = ~alu_res[ALU_W-1];
    assign bin_acc   = bin_valid && bin_ready;
    assign res_free  = !res_valid_reg || res_ready;
    assign csum_zero = (csum_reg == '0);
    assign div_r     = {rem_reg, dshift_reg[MEAN_W-1]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (bin_valid) state_next = S_MUL;
            S_MUL:   state_next = S_ADD_W;
            S_ADD_W: state_next = S_ADD_C;
            S_ADD_C: state_next = last_reg ? S_CHECK : S_IDLE;
            S_CHECK:
            begin
                if (csum_zero || alu_ge)
                    state_next = S_HOLD;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_HOLD;
            end
            S_HOLD:  if (res_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and alu operand selection
    always_comb
    begin
        bin_ready = 1'b0;
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        unique case (state_reg)
            S_IDLE:  bin_ready = 1'b1;
            S_MUL:   ;
            S_ADD_W:
            begin
                alu_a = {1'b0, wsum_reg};
                alu_b = ALU_W'(prod_reg);
            end
            S_ADD_C:
            begin
                alu_a = ALU_W'(csum_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            S_CHECK:
            begin
                alu_a   = {1'b0, wsum_reg};
                alu_b   = {1'b0, csum_reg, {OVF_SHIFT{1'b0}}};
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = ALU_W'(div_r);
                alu_b   = ALU_W'(csum_reg);
                alu_sub = 1'b1;
            end
            S_HOLD:  ;
            default: ;
        endcase
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            csum_reg      <= '0;
            wsum_reg      <= '0;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // saturating accumulation
            if (state_reg == S_ADD_W)
                wsum_reg <= alu_res[ALU_W-1] ? {WSUM_W{1'b1}} : alu_res[WSUM_W-1:0];
            if (state_reg == S_ADD_C)
                csum_reg <= (|alu_res[ALU_W-1:CNT_W]) ? {CNT_W{1'b1}} : alu_res[CNT_W-1:0];

            // division step counter
            if (state_reg == S_CHECK)
                div_cnt_reg <= '0;
            else if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;

            // result register and sum clear at end of pixel
            if (state_reg == S_HOLD && res_free)
            begin
                res_valid_reg <= 1'b1;
                csum_reg      <= '0;
                wsum_reg      <= '0;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (bin_acc)
        begin
            cnt_reg  <= bin.count;
            tm_reg   <= bin.bin_time;
            last_reg <= bin.last_bin;
        end

        if (state_reg == S_MUL)
            prod_reg <= cnt_reg * tm_reg;

        // overflow check and divider setup
        if (state_reg == S_CHECK)
        begin
            zero_reg   <= csum_zero;
            rem_reg    <= wsum_reg[WSUM_W-1:OVF_SHIFT];
            dshift_reg <= {wsum_reg[OVF_SHIFT-1:0], {FRAC_W{1'b0}}};
            if (csum_zero)
                quo_reg <= '0;
            else if (alu_ge)
                quo_reg <= {MEAN_W{1'b1}};
            else
                quo_reg <= '0;
        end

        // restoring division, one quotient bit per cycle
        if (state_reg == S_DIV)
        begin
            rem_reg    <= alu_ge ? alu_res[CNT_W-1:0] : div_r[CNT_W-1:0];
            dshift_reg <= {dshift_reg[MEAN_W-2:0], 1'b0};
            quo_reg    <= {quo_reg[MEAN_W-2:0], alu_ge};
        end

        if (state_reg == S_HOLD && res_free)
        begin
            res_reg.intensity      <= csum_reg;
            res_reg.mean_arrival   <= quo_reg;
            res_reg.zero_intensity <= zero_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    `FIMA_ASSERT_IMPLIES(a_zero_mean, res_valid && res.zero_intensity, res.mean_arrival == '0)
    `FIMA_ASSERT_IMPLIES(a_nonzero_int, res_valid && !res.zero_intensity, res.intensity != '0)
    `FIMA_ASSERT_IMPLIES(a_rem_below_div, state_reg == S_DIV, rem_reg < csum_reg)
    `FIMA_ASSERT_IMPLIES(a_empty_sums, state_reg == S_IDLE && csum_reg == '0, wsum_reg == '0)
    `FIMA_ASSERT_NEXT(a_clear_after_pixel, state_reg == S_HOLD && res_free,
        csum_reg == '0 && wsum_reg == '0 && res_valid)

endmodule

### dv/flim_intensity_mean_arrival_tb.sv
// testbench for flim_intensity_mean_arrival: streams histogram bins, predicts each pixel result
// depends on fima_pkg and the flim_intensity_mean_arrival rtl
// random valid/ready idling on both sides, with a stretch of back-to-back transactions
module flim_intensity_mean_arrival_tb;

    import fima_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT = 35;
    localparam int RANDOM_BINS = 2000;
    localparam int MAX_PRINTS = 50;

    // bin content styles for one pixel
    typedef enum int {
        PIX_RANDOM,
        PIX_LOW,
        PIX_EMPTY,
        PIX_FULL
    } pixel_style_t;

    logic clk;
    logic rst_n = 1'b0;
    logic bin_valid = 1'b0;
    logic bin_ready;
    bin_t bin = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    result_t res;

    // stimulus and expectations
    bin_t pending_bins[$];
    result_t expected_pixels[$];

    // predictor state
    logic [CNT_W-1:0] intensity_acc = '0;
    logic [WSUM_W-1:0] weighted_acc = '0;

    int bins_accepted = 0;
    int pixels_checked = 0;
    int empty_pixels = 0;
    int saturated_means = 0;
    int errors = 0;
    int cycles = 0;
    bit bin_took = 1'b0;
    logic steady;

    assign steady = (bins_accepted >= 800) && (bins_accepted < 1200);

    flim_intensity_mean_arrival i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bin_valid(bin_valid),
        .bin_ready(bin_ready),
        .bin      (bin),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycles, what, got, want);
    endtask

    // accumulate one bin; on a last bin push the pixel result and clear the sums
    task automatic accumulate_bin(input bin_t b);
        logic [CNT_W:0] cnt_next;
        logic [WSUM_W:0] wsum_next;
        logic [PROD_W-1:0] prod;
        logic [WSUM_W+FRAC_W-1:0] numer;
        logic [WSUM_W+FRAC_W-1:0] quot;
        result_t r;

        cnt_next = intensity_acc;
        cnt_next = cnt_next + b.count;
        intensity_acc = cnt_next[CNT_W] ? '1 : cnt_next[CNT_W-1:0];
        prod = b.count * b.bin_time;
        wsum_next = weighted_acc;
        wsum_next = wsum_next + prod;
        weighted_acc = wsum_next[WSUM_W] ? '1 : wsum_next[WSUM_W-1:0];
        if (b.last_bin)
        begin
            r.intensity = intensity_acc;
            if (intensity_acc == '0)
            begin
                r.mean_arrival = '0;
                r.zero_intensity = 1'b1;
            end
            else
            begin
                numer = {weighted_acc, {FRAC_W{1'b0}}};
                quot = numer / intensity_acc;
                r.mean_arrival = (quot >> MEAN_W) != '0 ? '1 : quot[MEAN_W-1:0];
                r.zero_intensity = 1'b0;
            end
            expected_pixels.push_back(r);
            intensity_acc = '0;
            weighted_acc = '0;
        end
    endtask

    // queue one pixel of nbins bins in the given style
    task automatic add_pixel(input int nbins, input pixel_style_t style);
        bin_t b;

        for (int i = 0; i < nbins; i++)
        begin
            case (style)
                PIX_EMPTY: b.count = '0;
                PIX_LOW:   b.count = 16'($urandom_range(0, 3));
                PIX_FULL:  b.count = '1;
                default:   b.count = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom);
            endcase
            b.bin_time = (style == PIX_FULL) ? '1 : 16'($urandom);
            b.last_bin = (i == nbins - 1);
            pending_bins.push_back(b);
        end
    endtask

    task automatic add_bin(input int cnt, input int tm, input bit last);
        bin_t b;

        b.count = 16'(cnt);
        b.bin_time = 16'(tm);
        b.last_bin = last;
        pending_bins.push_back(b);
    endtask

    // accepted input transaction feeds the predictor
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("flim_intensity_mean_arrival test failed");
            $finish;
        end
        else if (rst_n && bin_valid && bin_ready)
        begin
            accumulate_bin(bin);
            bins_accepted++;
            bin_took = 1'b1;
        end
    end

    // bin driver
    always @(negedge clk)
    begin
        if (rst_n && (!bin_valid || bin_took))
        begin
            bin_took = 1'b0;
            if (pending_bins.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                bin_valid <= 1'b1;
                bin <= pending_bins.pop_front();
            end
            else
            begin
                bin_valid <= 1'b0;
            end
        end
    end

    // result ready stalls
    always @(negedge clk)
    begin
        if (rst_n)
            res_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch("result with no pixel pending", 64'(res), 64'(0));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res.intensity !== want.intensity)
                    report_mismatch("intensity", 64'(res.intensity), 64'(want.intensity));
                if (res.mean_arrival !== want.mean_arrival)
                    report_mismatch("mean_arrival", 64'(res.mean_arrival),
                                    64'(want.mean_arrival));
                if (res.zero_intensity !== want.zero_intensity)
                    report_mismatch("zero_intensity", 64'(res.zero_intensity),
                                    64'(want.zero_intensity));
                pixels_checked++;
                if (want.zero_intensity)
                    empty_pixels++;
                if (want.mean_arrival == '1)
                    saturated_means++;
            end
        end
    end

    initial
    begin
        int added;
        int nbins;
        int pick;

        // directed pixels: empty, extremes, fractions
        add_bin(0, 16'hffff, 1'b1);
        add_bin(16'hffff, 16'hffff, 1'b1);
        add_bin(1, 0, 1'b1);
        add_bin(1, 1, 1'b1);
        add_bin(0, 16'hffff, 1'b0);
        add_bin(0, 1, 1'b0);
        add_bin(0, 0, 1'b1);
        add_bin(1, 0, 1'b0);
        add_bin(2, 1, 1'b1);
        add_bin(16'hffff, 0, 1'b0);
        add_bin(0, 16'hffff, 1'b1);
        add_bin(16'h8000, 16'h5555, 1'b0);
        add_bin(16'h7fff, 16'haaaa, 1'b0);
        add_bin(3, 16'hffff, 1'b1);
        add_pixel(6, PIX_LOW);

        // random pixels, mostly short
        added = 0;
        while (added < RANDOM_BINS)
        begin
            nbins = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                add_pixel(nbins, PIX_EMPTY);
            else if (pick == 1)
                add_pixel(nbins, PIX_LOW);
            else if (pick == 2)
                add_pixel(nbins, PIX_FULL);
            else
                add_pixel(nbins, PIX_RANDOM);
            added += nbins;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bins.size() > 0 || bin_valid)
            @(posedge clk);
        while (expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bins accepted, %0d pixel results checked", bins_accepted, pixels_checked);
        $display("%0d empty pixels, %0d pixels with saturated mean", empty_pixels,
                 saturated_means);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("flim_intensity_mean_arrival test passed");
        else
            $display("flim_intensity_mean_arrival test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/fima_pkg.sv
rtl/core/flim_intensity_mean_arrival.sv
dv/flim_intensity_mean_arrival_tb.sv
